>>> hdl/kvsp_pkg.sv
// Shared types, character codes and slot numbering for the key=value sample line parser.
// No dependencies; imported by every module of the block.
package kvsp_pkg;

    localparam int VALUE_BITS = 32;
    localparam int OUT_BITS   = 32;
    localparam int SLOT_COUNT = 9;
    localparam int SLOT_BITS  = 4;

    localparam logic [7:0] CH_EQ   = 8'h3D; // '='
    localparam logic [7:0] CH_H    = 8'h68; // 'h'
    localparam logic [7:0] CH_O    = 8'h6F; // 'o'
    localparam logic [7:0] CH_M    = 8'h6D; // 'm'
    localparam logic [7:0] CH_X    = 8'h78; // 'x'
    localparam logic [7:0] CH_S    = 8'h73; // 's'
    localparam logic [7:0] CH_A    = 8'h61; // 'a'
    localparam logic [7:0] CH_0    = 8'h30; // '0'
    localparam logic [7:0] CH_5    = 8'h35; // '5'
    localparam logic [7:0] CH_9    = 8'h39; // '9'
    localparam logic [7:0] CH_NL   = 8'h0A; // newline

    localparam logic [SLOT_BITS-1:0] SLOT_SEQ  = SLOT_BITS'(0);
    localparam logic [SLOT_BITS-1:0] SLOT_CH0  = SLOT_BITS'(1);
    localparam logic [SLOT_BITS-1:0] SLOT_TS   = SLOT_BITS'(7);
    localparam logic [SLOT_BITS-1:0] SLOT_TD   = SLOT_BITS'(8);
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOT_COUNT - 1);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [SLOT_COUNT-1:0][VALUE_BITS-1:0] t_slots;

    // decoded view of one byte in the context of the previous byte
    typedef struct packed {
        logic                 is_eq;
        logic                 is_acc;
        logic                 is_nl;
        logic                 key_hit;
        logic [SLOT_BITS-1:0] key_slot;
        logic [3:0]           digit;
    } t_dec;

    // low OUT_BITS of a slot value, zero-extended when the slot is narrower
    function automatic logic [OUT_BITS-1:0] to_out(input t_value v);
        logic [OUT_BITS+VALUE_BITS-1:0] ext;
        ext = {{OUT_BITS{1'b0}}, v};
        return ext[OUT_BITS-1:0];
    endfunction

endpackage

>>> hdl/key_value_sample_line_parser_core.sv
// Key=value sample line parser top level: input register, parser state, result register.
// Depends on kvsp_pkg, kvsp_decode and kvsp_slots.
//
// Usage:
//   Input channel i_valid/o_ready carries one ASCII byte per item on i_byte_in.
//   Output channel o_valid/i_ready carries one result per newline byte: the nine
//   slot values (sequence number, channels 0-5, timestamp, time delta).
//   '=' picks a slot from the byte before it and clears it; digits not following
//   'h' accumulate as value*10+digit, wrapping at 2^32; other bytes only move on.
//   Throughput: one byte per cycle while o_ready is high. A newline passes
//   through the input register, then its result is held in the result register.
//   Reset (synchronous, active low) clears the previous byte, the slot select,
//   all slot values and both valid flags.
//   Receiver stall: while a result waits, bytes other than newline keep flowing;
//   a second newline waits in the input register, and o_ready drops until the
//   pending result is taken.
module key_value_sample_line_parser_core
    import kvsp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_byte_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OUT_BITS-1:0] o_seq_number,
    output logic [OUT_BITS-1:0] o_chan0,
    output logic [OUT_BITS-1:0] o_chan1,
    output logic [OUT_BITS-1:0] o_chan2,
    output logic [OUT_BITS-1:0] o_chan3,
    output logic [OUT_BITS-1:0] o_chan4,
    output logic [OUT_BITS-1:0] o_chan5,
    output logic [OUT_BITS-1:0] o_time_stamp,
    output logic [OUT_BITS-1:0] o_time_delta
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_out_valid;
    logic [SLOT_COUNT-1:0][OUT_BITS-1:0] r_out;

    t_dec       dec;
    logic [7:0] prev;
    t_slots     slots;
    logic       stall, advance, emit;

    kvsp_decode u_decode (
        .i_byte (r_byte),
        .i_prev (prev),
        .o_dec  (dec)
    );

    assign stall   = r_in_valid && dec.is_nl && r_out_valid && !i_ready;
    assign advance = !stall;
    assign emit    = r_in_valid && advance && dec.is_nl;
    assign o_ready = advance;

    kvsp_slots u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && advance),
        .i_byte  (r_byte),
        .i_dec   (dec),
        .o_prev  (prev),
        .o_slots (slots)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_in_valid <= i_valid;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_valid) begin
            r_byte <= i_byte_in;
        end
        if (emit) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_out[i] <= to_out(slots[i]);
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_seq_number = r_out[0];
    assign o_chan0      = r_out[1];
    assign o_chan1      = r_out[2];
    assign o_chan2      = r_out[3];
    assign o_chan3      = r_out[4];
    assign o_chan4      = r_out[5];
    assign o_chan5      = r_out[6];
    assign o_time_stamp = r_out[7];
    assign o_time_delta = r_out[8];

`ifndef SYNTHESIS
    // input side only blocks behind a pending, untaken result
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("o_ready low without a stalled result");

    // a held byte stays put
    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_byte)))
        else $error("stalled byte lost or changed");

    // a new result only follows a newline leaving the input register
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid && !i_ready)) |->
            $past(r_in_valid && (r_byte == CH_NL)))
        else $error("result without a newline");
`endif

endmodule

>>> hdl/kvsp_decode.sv
// Byte classifier: '=', counted digit, newline, and the slot picked by a key byte.
// Depends on kvsp_pkg.
module kvsp_decode
    import kvsp_pkg::*;
(
    input  logic [7:0] i_byte,
    input  logic [7:0] i_prev,
    output t_dec       o_dec
);

    always_comb begin
        o_dec          = '0;
        o_dec.digit    = i_byte[3:0];
        o_dec.is_eq    = (i_byte == CH_EQ);
        o_dec.is_acc   = !o_dec.is_eq && (i_byte inside {[CH_0:CH_9]}) && (i_prev != CH_H);
        o_dec.is_nl    = (i_byte == CH_NL);
        o_dec.key_hit  = 1'b1;
        o_dec.key_slot = SLOT_SEQ;
        if (i_prev inside {CH_O, CH_M, CH_X}) begin
            o_dec.key_slot = SLOT_SEQ;
        end else if (i_prev inside {[CH_0:CH_5]}) begin
            o_dec.key_slot = SLOT_BITS'(i_prev[3:0]) + SLOT_CH0;
        end else if (i_prev == CH_S) begin
            o_dec.key_slot = SLOT_TS;
        end else if (i_prev == CH_A) begin
            o_dec.key_slot = SLOT_TD;
        end else begin
            o_dec.key_hit  = 1'b0;
        end
    end

endmodule

>>> hdl/kvsp_slots.sv
// Parser state: previous byte, current slot and the nine slot accumulators.
// Depends on kvsp_pkg; driven by the decode of kvsp_decode.
module kvsp_slots
    import kvsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_byte,
    input  t_dec       i_dec,
    output logic [7:0] o_prev,
    output t_slots     o_slots
);

    logic [7:0]           r_prev, n_prev;
    logic [SLOT_BITS-1:0] r_sel, n_sel;
    t_slots               r_slots, n_slots;
    logic [SLOT_BITS-1:0] cur_slot, clr_slot;
    t_value               acc;

    always_comb begin
        cur_slot = (r_sel > SLOT_LAST) ? SLOT_SEQ : r_sel;
        n_sel    = (i_dec.is_eq && i_dec.key_hit) ? i_dec.key_slot : r_sel;
        clr_slot = (n_sel > SLOT_LAST) ? SLOT_SEQ : n_sel;
        // value*10 + digit as two shifts and adds
        acc      = (r_slots[cur_slot] << 3) + (r_slots[cur_slot] << 1)
                   + t_value'(i_dec.digit);
        n_prev   = i_byte;
        n_slots  = r_slots;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (i_dec.is_eq && (clr_slot == SLOT_BITS'(i))) begin
                n_slots[i] = '0;
            end else if (i_dec.is_acc && (cur_slot == SLOT_BITS'(i))) begin
                n_slots[i] = acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_sel   <= '0;
            r_slots <= '0;
        end else if (i_en) begin
            r_prev  <= n_prev;
            r_sel   <= n_sel;
            r_slots <= n_slots;
        end
    end

    assign o_prev  = r_prev;
    assign o_slots = r_slots;

endmodule
